[rtl/core/ipv4_source_range_filter_assert.svh]
// Assertion macros used by the filter top level.
// Each macro expects clk and rst in scope.
`ifndef IPV4_SOURCE_RANGE_FILTER_ASSERT_SVH
`define IPV4_SOURCE_RANGE_FILTER_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define SRF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset
`define SRF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/srf_pkg.sv]
// ----------------------------------------------------------------------------
// srf_pkg
// Shared constants, codes and the token type that moves down the rule chain.
// ----------------------------------------------------------------------------
package srf_pkg;

  // Rule table depth, one chain cell per entry
  localparam int RULE_DEPTH = 64;
  // Cell id width: wide enough for every cell, never narrower than a rule index
  localparam int ID_W = (RULE_DEPTH > 64) ? $clog2(RULE_DEPTH) : 6;

  localparam int IDX_W   = 6;
  localparam int POS_W   = 6;
  localparam int ADDR_W  = 32;
  localparam int S_DATA_W = 80;
  localparam int M_DATA_W = 16;

  // Input tdata layout
  localparam int BYTE_LSB  = 0;
  localparam int RIDX_LSB  = 8;
  localparam int RADDR_LSB = 14;
  localparam int RMASK_LSB = 46;
  localparam int RVAL_BIT  = 78;

  // Frame header constants
  localparam logic [POS_W-1:0] POS_MAX      = 6'd63;
  localparam logic [POS_W-1:0] POS_TYPE_HI  = 6'd12;
  localparam logic [POS_W-1:0] POS_TYPE_LO  = 6'd13;
  localparam logic [POS_W-1:0] POS_SRC_FIRST = 6'd26;
  localparam logic [POS_W-1:0] POS_SRC_LAST = 6'd29;
  localparam logic [POS_W-1:0] IPV4_MIN_LEN = 6'd34;
  localparam logic [15:0]      TYPE_IPV4    = 16'h0800;

  // Request opcodes
  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_RULE  = 1'b1;

  // Verdict and reason codes
  localparam logic       VERDICT_PASS = 1'b0;
  localparam logic       VERDICT_DROP = 1'b1;
  localparam logic [1:0] REASON_SHORT   = 2'd0;
  localparam logic [1:0] REASON_NOMATCH = 2'd1;
  localparam logic [1:0] REASON_MATCH   = 2'd2;

  typedef enum logic [1:0] {
    TOK_NONE  = 2'd0,
    TOK_QUERY = 2'd1,
    TOK_WRITE = 2'd2
  } tok_kind_t;

  // One chain slot: a lookup query or a rule write
  typedef struct packed {
    tok_kind_t          kind;
    logic               short_f;   // query: frame too short or not IPv4
    logic               done;      // query: search finished
    logic               hit;       // query: a rule matched
    logic [IDX_W-1:0]   hit_idx;   // query: matching rule
    logic [IDX_W-1:0]   rule_idx;  // write: target slot
    logic [ADDR_W-1:0]  addr;      // query: source address, write: rule address
    logic [ADDR_W-1:0]  mask;      // write: rule mask
    logic               rvalid;    // write: entry valid bit
  } tok_t;

endpackage

[rtl/core/srf_front.sv]
// ----------------------------------------------------------------------------
// srf_front
// Parses frame bytes, tracks position, type and source address, and issues
// query or rule-write tokens into the head of the rule chain.
// ----------------------------------------------------------------------------
module srf_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           adv,
  input  logic                           s_tvalid,
  input  logic [srf_pkg::S_DATA_W-1:0]   s_tdata,
  input  logic                           s_tlast,
  input  logic [0:0]                     s_tuser,
  output srf_pkg::tok_t                  tok
);
  import srf_pkg::*;

  logic [POS_W-1:0]  pos;
  logic [15:0]       frame_type;
  logic [ADDR_W-1:0] src_addr;

  logic [POS_W-1:0]  pos_next;
  logic [15:0]       type_next;
  logic [ADDR_W-1:0] src_next;
  logic [7:0]        byte_in;
  logic              accept;
  tok_t              tok_next;

  assign byte_in = s_tdata[BYTE_LSB +: 8];
  assign accept  = adv && s_tvalid;

  // Update header fields for the incoming byte
  always_comb begin
    pos_next  = (pos < POS_MAX) ? pos + 1'b1 : pos;
    type_next = frame_type;
    src_next  = src_addr;
    if (pos == POS_TYPE_HI) begin
      type_next = {byte_in, frame_type[7:0]};
    end else if (pos == POS_TYPE_LO) begin
      type_next = {frame_type[15:8], byte_in};
    end else if (pos >= POS_SRC_FIRST && pos <= POS_SRC_LAST) begin
      src_next = {src_addr[ADDR_W-9:0], byte_in};
    end
  end

  // Build the token for this request
  always_comb begin
    tok_next          = '0;
    tok_next.kind     = TOK_NONE;
    tok_next.rule_idx = s_tdata[RIDX_LSB +: IDX_W];
    tok_next.mask     = s_tdata[RMASK_LSB +: ADDR_W];
    tok_next.rvalid   = s_tdata[RVAL_BIT];
    if (s_tuser[0] == OP_RULE) begin
      tok_next.addr = s_tdata[RADDR_LSB +: ADDR_W];
      if (accept) begin
        tok_next.kind = TOK_WRITE;
      end
    end else begin
      tok_next.addr    = src_next;
      tok_next.short_f = (pos_next < IPV4_MIN_LEN) || (type_next != TYPE_IPV4);
      if (accept && s_tlast) begin
        tok_next.kind = TOK_QUERY;
      end
    end
  end

  // Advance frame state and the head token
  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      frame_type <= '0;
      src_addr   <= '0;
      tok.kind   <= TOK_NONE;
    end else if (adv) begin
      tok <= tok_next;
      if (accept && s_tuser[0] == OP_FRAME) begin
        if (s_tlast) begin
          pos        <= '0;
          frame_type <= '0;
          src_addr   <= '0;
        end else begin
          pos        <= pos_next;
          frame_type <= type_next;
          src_addr   <= src_next;
        end
      end
    end
  end

endmodule

[rtl/core/srf_cell.sv]
// ----------------------------------------------------------------------------
// srf_cell
// One rule table entry. Applies rule writes aimed at it and checks passing
// queries against its address and mask, then hands the token on.
// ----------------------------------------------------------------------------
module srf_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  logic [srf_pkg::ID_W-1:0] cell_id,
  input  srf_pkg::tok_t            tok_in,
  output srf_pkg::tok_t            tok_out
);
  import srf_pkg::*;

  logic [ADDR_W-1:0] rule_addr;
  logic [ADDR_W-1:0] rule_mask;
  logic              rule_valid;

  logic              wr_hit;
  tok_t              tok_next;

  assign wr_hit = (tok_in.kind == TOK_WRITE) && (ID_W'(tok_in.rule_idx) == cell_id);

  // Resolve a pending query at this entry
  always_comb begin
    tok_next = tok_in;
    if (tok_in.kind == TOK_QUERY && !tok_in.short_f && !tok_in.done) begin
      if (!rule_valid) begin
        tok_next.done = 1'b1;
      end else if (((tok_in.addr ^ rule_addr) & rule_mask) == '0) begin
        tok_next.done    = 1'b1;
        tok_next.hit     = 1'b1;
        tok_next.hit_idx = cell_id[IDX_W-1:0];
      end
    end
  end

  // Store the entry on a matching write
  always_ff @(posedge clk) begin
    if (rst) begin
      rule_valid <= 1'b0;
    end else if (adv && wr_hit) begin
      rule_valid <= tok_in.rvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && wr_hit) begin
      rule_addr <= tok_in.addr;
      rule_mask <= tok_in.mask;
    end
  end

  // Hand the token to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.kind <= TOK_NONE;
    end else if (adv) begin
      tok_out <= tok_next;
    end
  end

endmodule

[rtl/core/ipv4_source_range_filter.sv]
// Path: a frame's last byte gives its verdict on m_tdata after it passes one head
//   stage, one stage per rule cell and the output register.
// Throughput: one request per cycle; the whole rule chain moves in lockstep and
//   stalls only while the output register holds a verdict that is not taken.
// Reset: synchronous; clears all rule valid bits, frame state and tokens at once.
// ----------------------------------------------------------------------------
// ipv4_source_range_filter
// Ethernet IPv4 source address blocklist: frame bytes and rule writes flow
// through a chain of rule cells; a verdict leaves on the frame's last byte.
// ----------------------------------------------------------------------------
`include "ipv4_source_range_filter_assert.svh"

module ipv4_source_range_filter (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // byte_value[7:0], rule_index[13:8], rule_address[45:14], rule_mask[77:46],
  // rule_valid[78], zero[79]
  input  logic [srf_pkg::S_DATA_W-1:0] s_tdata,
  input  logic                         s_tlast,   // last_byte
  input  logic [0:0]                   s_tuser,   // opcode[0]
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // verdict[0], reason[2:1], match_index[8:3], zero[15:9]
  output logic [srf_pkg::M_DATA_W-1:0] m_tdata
);
  import srf_pkg::*;

  logic             adv;
  tok_t             tok [RULE_DEPTH+1];
  tok_t             tok_tail;
  logic             verdict;
  logic [1:0]       reason;
  logic [IDX_W-1:0] match_index;

  // Move the chain whenever the output register can take a verdict
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign tok_tail = tok[RULE_DEPTH];

  srf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .s_tvalid (s_tvalid),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .tok      (tok[0])
  );

  for (genvar k = 0; k < RULE_DEPTH; k++) begin : g_cell
    srf_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .cell_id (ID_W'(k)),
      .tok_in  (tok[k]),
      .tok_out (tok[k+1])
    );
  end

  // Register the verdict of a query leaving the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= (tok_tail.kind == TOK_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (tok_tail.short_f) begin
        verdict     <= VERDICT_PASS;
        reason      <= REASON_SHORT;
        match_index <= '0;
      end else if (tok_tail.hit) begin
        verdict     <= VERDICT_DROP;
        reason      <= REASON_MATCH;
        match_index <= tok_tail.hit_idx;
      end else begin
        verdict     <= VERDICT_PASS;
        reason      <= REASON_NOMATCH;
        match_index <= '0;
      end
    end
  end

  assign m_tdata = {(M_DATA_W - 1 - 2 - IDX_W)'(0), match_index, reason, verdict};

  // A query reaching the end of the chain always yields a verdict
  `SRF_ASSERT_NXT(a_query_out, adv && tok_tail.kind == TOK_QUERY, m_tvalid, "query lost at chain end")
  // A drop always carries the rule-match reason
  `SRF_ASSERT_IMP(a_drop_reason, m_tvalid && verdict == VERDICT_DROP, reason == REASON_MATCH, "drop without match reason")
  // Short or non-IPv4 frames never match a rule
  `SRF_ASSERT_IMP(a_short_nohit, tok_tail.kind == TOK_QUERY && tok_tail.short_f, !tok_tail.hit, "short frame matched a rule")
  // A stalled chain keeps its tail token
  `SRF_ASSERT_NXT(a_stall_hold, !adv, tok_tail.kind == $past(tok_tail.kind), "chain moved while stalled")

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the IPv4 source address blocklist filter. Frames go
// in byte by byte with rule writes mixed in, and every verdict is checked
// against a cycle-free model of the rule table kept inside this bench.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srf_pkg::*;

  localparam int TOTAL_ITEMS    = 1300;
  localparam int MIN_PHASES     = 3;
  localparam int CALM_TAIL      = 1150;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;

  // One request as seen on the slave side
  typedef struct packed {
    logic              op;
    logic [7:0]        byte_val;
    logic              last;
    logic [IDX_W-1:0]  idx;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] mask;
    logic              valid;
  } filt_req_t;

  // One verdict as seen on the master side
  typedef struct packed {
    logic             verdict;
    logic [1:0]       reason;
    logic [IDX_W-1:0] idx;
  } verdict_t;

  // Verdict typed in by hand for a directed frame
  typedef struct packed {
    logic     pinned;
    verdict_t want;
  } pin_t;

  // Directed row: a rule write or a whole frame
  typedef struct packed {
    logic              is_rule;
    logic [7:0]        len;
    logic [15:0]       etype;
    logic [ADDR_W-1:0] src;
    logic [IDX_W-1:0]  idx;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] mask;
    logic              valid;
    logic              pinned;
    verdict_t          want;
  } plan_row_t;

  localparam verdict_t V_SHORT   = '{VERDICT_PASS, REASON_SHORT, 6'd0};
  localparam verdict_t V_NOMATCH = '{VERDICT_PASS, REASON_NOMATCH, 6'd0};
  localparam verdict_t V_NONE    = '0;

  // is_rule, len, etype, src, idx, addr, mask, valid, pinned, want
  localparam plan_row_t PLAN [0:21] = '{
    '{1'b0, 8'd1,   16'h0000, 32'h0000_0000, 6'd0, 32'h0, 32'h0, 1'b0, 1'b1, V_SHORT},
    '{1'b0, 8'd13,  16'h0800, 32'hC0A8_0101, 6'd0, 32'h0, 32'h0, 1'b0, 1'b1, V_SHORT},
    '{1'b0, 8'd14,  16'h0800, 32'hC0A8_0101, 6'd0, 32'h0, 32'h0, 1'b0, 1'b1, V_SHORT},
    '{1'b0, 8'd33,  16'h0800, 32'hC0A8_0101, 6'd0, 32'h0, 32'h0, 1'b0, 1'b1, V_SHORT},
    '{1'b0, 8'd34,  16'h0801, 32'hC0A8_0101, 6'd0, 32'h0, 32'h0, 1'b0, 1'b1, V_SHORT},
    '{1'b0, 8'd34,  16'h0008, 32'hC0A8_0101, 6'd0, 32'h0, 32'h0, 1'b0, 1'b1, V_SHORT},
    '{1'b0, 8'd34,  16'h0800, 32'hC0A8_0101, 6'd0, 32'h0, 32'h0, 1'b0, 1'b1, V_NOMATCH},
    '{1'b1, 8'd0,   16'h0000, 32'h0, 6'd0, 32'hC0A8_0000, 32'hFFFF_0000, 1'b1, 1'b0, V_NONE},
    '{1'b0, 8'd34,  16'h0800, 32'hC0A8_FFFE, 6'd0, 32'h0, 32'h0, 1'b0, 1'b1,
      '{VERDICT_DROP, REASON_MATCH, 6'd0}},
    '{1'b0, 8'd40,  16'h0800, 32'hC0A9_0001, 6'd0, 32'h0, 32'h0, 1'b0, 1'b1, V_NOMATCH},
    '{1'b1, 8'd0,   16'h0000, 32'h0, 6'd2, 32'h0, 32'h0, 1'b1, 1'b0, V_NONE},
    '{1'b0, 8'd40,  16'h0800, 32'h0A00_0001, 6'd0, 32'h0, 32'h0, 1'b0, 1'b1, V_NOMATCH},
    '{1'b1, 8'd0,   16'h0000, 32'h0, 6'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, V_NONE},
    '{1'b0, 8'd63,  16'h0800, 32'hFFFF_FFFF, 6'd0, 32'h0, 32'h0, 1'b0, 1'b1,
      '{VERDICT_DROP, REASON_MATCH, 6'd1}},
    '{1'b0, 8'd200, 16'h0800, 32'h0A00_0001, 6'd0, 32'h0, 32'h0, 1'b0, 1'b1,
      '{VERDICT_DROP, REASON_MATCH, 6'd2}},
    '{1'b0, 8'd64,  16'h0800, 32'h0000_0000, 6'd0, 32'h0, 32'h0, 1'b0, 1'b0, V_NONE},
    '{1'b1, 8'd0,   16'h0000, 32'h0, 6'd2, 32'h0, 32'h0, 1'b0, 1'b0, V_NONE},
    '{1'b0, 8'd34,  16'h0800, 32'hFFFF_FFFE, 6'd0, 32'h0, 32'h0, 1'b0, 1'b0, V_NONE},
    '{1'b1, 8'd0,   16'h0000, 32'h0, 6'd63, 32'hDEAD_BEEF, 32'hFFFF_FFFF, 1'b1, 1'b0, V_NONE},
    '{1'b0, 8'd34,  16'h0800, 32'hDEAD_BEEF, 6'd0, 32'h0, 32'h0, 1'b0, 1'b0, V_NONE},
    '{1'b1, 8'd0,   16'h0000, 32'h0, 6'd0, 32'h0, 32'h0, 1'b0, 1'b0, V_NONE},
    '{1'b0, 8'd34,  16'h0800, 32'hC0A8_0001, 6'd0, 32'h0, 32'h0, 1'b0, 1'b1, V_NOMATCH}
  };

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata;
  logic                  s_tlast;
  logic [0:0]            s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [M_DATA_W-1:0]   m_tdata;

  // Shadow rule table and frame state
  logic [ADDR_W-1:0] blk_addr [RULE_DEPTH];
  logic [ADDR_W-1:0] blk_mask [RULE_DEPTH];
  logic              blk_valid [RULE_DEPTH];
  logic [POS_W-1:0]  frame_pos;
  logic [15:0]       frame_etype;
  logic [ADDR_W-1:0] frame_src;

  verdict_t verdict_q [$];
  pin_t     pinned_q [$];

  int  errors;
  int  quiet_cycles;
  int  items_sent;
  int  gap_odds;
  bit  no_idle;

  ipv4_source_range_filter dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic flag_error(input string what);
    errors++;
    if (errors <= MAX_REPORTS) begin
      $display("ERROR @%0t: %s", $time, what);
    end
  endtask

  // Apply one accepted request to the shadow table; queue a verdict on last byte
  task automatic track_request(input filt_req_t r);
    verdict_t v;
    pin_t     pin;
    bit       searching;
    int       i;
    if (r.op == OP_RULE) begin
      blk_addr[r.idx]  = r.addr;
      blk_mask[r.idx]  = r.mask;
      blk_valid[r.idx] = r.valid;
      return;
    end
    if (frame_pos == POS_TYPE_HI) begin
      frame_etype[15:8] = r.byte_val;
    end else if (frame_pos == POS_TYPE_LO) begin
      frame_etype[7:0] = r.byte_val;
    end else if (frame_pos >= POS_SRC_FIRST && frame_pos <= POS_SRC_LAST) begin
      frame_src = {frame_src[23:0], r.byte_val};
    end
    if (frame_pos != POS_MAX) begin
      frame_pos++;
    end
    if (!r.last) begin
      return;
    end
    v = V_SHORT;
    if (frame_pos >= IPV4_MIN_LEN && frame_etype == TYPE_IPV4) begin
      v = V_NOMATCH;
      searching = 1'b1;
      // Walk the table in order; an empty slot ends the search
      for (i = 0; i < RULE_DEPTH; i++) begin
        if (searching) begin
          if (!blk_valid[i]) begin
            searching = 1'b0;
          end else if ((frame_src & blk_mask[i]) == (blk_addr[i] & blk_mask[i])) begin
            v = '{VERDICT_DROP, REASON_MATCH, i[IDX_W-1:0]};
            searching = 1'b0;
          end
        end
      end
    end
    if (pinned_q.size() != 0) begin
      pin = pinned_q.pop_front();
      if (pin.pinned) begin
        v = pin.want;
      end
    end
    verdict_q.push_back(v);
    frame_pos   = '0;
    frame_etype = '0;
    frame_src   = '0;
  endtask

  // Check verdicts, track requests and run the watchdog
  always @(posedge clk) begin : monitor
    filt_req_t r;
    verdict_t  got;
    verdict_t  want;
    bit        moved;
    if (rst) begin
      for (int i = 0; i < RULE_DEPTH; i++) begin
        blk_addr[i]  = '0;
        blk_mask[i]  = '0;
        blk_valid[i] = 1'b0;
      end
      frame_pos    = '0;
      frame_etype  = '0;
      frame_src    = '0;
      quiet_cycles = 0;
    end else begin
      moved = 1'b0;
      if (m_tvalid && m_tready) begin
        moved = 1'b1;
        got.verdict = m_tdata[0];
        got.reason  = m_tdata[2:1];
        got.idx     = m_tdata[8:3];
        if (verdict_q.size() == 0) begin
          flag_error($sformatf("unexpected verdict %0d reason %0d index %0d",
                               got.verdict, got.reason, got.idx));
        end else begin
          want = verdict_q.pop_front();
          if (got.verdict !== want.verdict || got.reason !== want.reason ||
              got.idx !== want.idx) begin
            flag_error($sformatf(
              "verdict/reason/index expected %0d/%0d/%0d got %0d/%0d/%0d",
              want.verdict, want.reason, want.idx, got.verdict, got.reason, got.idx));
          end
        end
      end
      if (s_tvalid && s_tready) begin
        moved      = 1'b1;
        r.op       = s_tuser[0];
        r.last     = s_tlast;
        r.byte_val = s_tdata[BYTE_LSB +: 8];
        r.idx      = s_tdata[RIDX_LSB +: IDX_W];
        r.addr     = s_tdata[RADDR_LSB +: ADDR_W];
        r.mask     = s_tdata[RMASK_LSB +: ADDR_W];
        r.valid    = s_tdata[RVAL_BIT];
        track_request(r);
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("ipv4_source_range_filter verification failed");
        $finish;
      end
    end
  end

  // Master side: stall in bursts, with calm stretches
  initial begin
    int odds;
    int stall;
    int span;
    odds     = 0;
    stall    = 0;
    span     = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (span == 0) begin
        span = $urandom_range(64, 256);
        case ($urandom_range(0, 2))
          0: odds = 0;
          1: odds = 3;
          default: odds = 10;
        endcase
      end
      span--;
      if (stall > 0) begin
        stall--;
        m_tready <= 1'b0;
      end else if (!no_idle && odds != 0 && $urandom_range(1, odds) == 1) begin
        stall = $urandom_range(1, 7) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  function automatic filt_req_t rand_req();
    filt_req_t r;
    r.op       = 1'($urandom_range(0, 1));
    r.byte_val = 8'($urandom_range(0, 255));
    r.last     = 1'($urandom_range(0, 1));
    r.idx      = IDX_W'($urandom_range(0, RULE_DEPTH - 1));
    r.addr     = $urandom;
    r.mask     = $urandom;
    r.valid    = 1'($urandom_range(0, 1));
    return r;
  endfunction

  // Present one request at the falling edge and hold it until taken
  task automatic send_item(input filt_req_t r);
    logic [S_DATA_W-1:0] word;
    if (!no_idle && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    word = '0;
    word[BYTE_LSB +: 8]       = r.byte_val;
    word[RIDX_LSB +: IDX_W]   = r.idx;
    word[RADDR_LSB +: ADDR_W] = r.addr;
    word[RMASK_LSB +: ADDR_W] = r.mask;
    word[RVAL_BIT]            = r.valid;
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    s_tlast  <= r.last;
    s_tuser  <= r.op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
    if (items_sent >= CALM_TAIL) begin
      no_idle = 1'b1;
    end
  endtask

  task automatic send_rule(input logic [IDX_W-1:0] idx, input logic [ADDR_W-1:0] addr,
                           input logic [ADDR_W-1:0] mask, input logic valid);
    filt_req_t r;
    r       = rand_req();
    r.op    = OP_RULE;
    r.idx   = idx;
    r.addr  = addr;
    r.mask  = mask;
    r.valid = valid;
    send_item(r);
  endtask

  // Stream one frame; with mix set, slip random rule writes between bytes
  task automatic send_frame(input int len, input logic [15:0] etype,
                            input logic [ADDR_W-1:0] src, input bit mix);
    filt_req_t r;
    for (int p = 0; p < len; p++) begin
      if (mix && $urandom_range(0, 29) == 0) begin
        r    = rand_req();
        r.op = OP_RULE;
        send_item(r);
      end
      r      = rand_req();
      r.op   = OP_FRAME;
      r.last = (p == len - 1);
      if (p == POS_TYPE_HI) begin
        r.byte_val = etype[15:8];
      end else if (p == POS_TYPE_LO) begin
        r.byte_val = etype[7:0];
      end else if (p >= POS_SRC_FIRST && p <= POS_SRC_LAST) begin
        r.byte_val = src[8 * (POS_SRC_LAST - p) +: 8];
      end
      send_item(r);
    end
  endtask

  // Hold off the sender until every pending verdict is out
  task automatic drain_verdicts();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (verdict_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    int phase_no;
    int k;
    int nf;
    int kind;
    int len;
    int plen;
    int j;
    logic [15:0]       etype;
    logic [ADDR_W-1:0] src;
    logic [ADDR_W-1:0] mask;
    errors     = 0;
    items_sent = 0;
    no_idle    = 1'b0;
    gap_odds   = 6;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tlast    = 1'b0;
    s_tuser    = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table
    for (int n = 0; n < $size(PLAN); n++) begin
      if (PLAN[n].is_rule) begin
        send_rule(PLAN[n].idx, PLAN[n].addr, PLAN[n].mask, PLAN[n].valid);
      end else begin
        pinned_q.push_back('{PLAN[n].pinned, PLAN[n].want});
        send_frame(PLAN[n].len, PLAN[n].etype, PLAN[n].src, 1'b0);
      end
    end

    // Random phases: build a rule prefix, then run frames against it
    phase_no = 0;
    while (items_sent < TOTAL_ITEMS || phase_no < MIN_PHASES) begin
      case ($urandom_range(0, 2))
        0: gap_odds = 0;
        1: gap_odds = 4;
        default: gap_odds = 12;
      endcase
      if (phase_no == 2) begin
        // Fill the whole table with exact-match rules
        for (int t = 0; t < RULE_DEPTH; t++) begin
          send_rule(IDX_W'(t), $urandom, 32'hFFFF_FFFF, 1'b1);
        end
        send_frame($urandom_range(34, 63), TYPE_IPV4, $urandom, 1'b0);
        send_frame(34, TYPE_IPV4, blk_addr[RULE_DEPTH - 1], 1'b0);
        send_frame($urandom_range(34, 63), TYPE_IPV4,
                   blk_addr[$urandom_range(0, RULE_DEPTH - 1)], 1'b0);
      end else begin
        k = $urandom_range(0, 6);
        for (int t = 0; t < k; t++) begin
          plen = $urandom_range(0, 32);
          mask = (plen == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - plen));
          send_rule(IDX_W'(t), $urandom, mask, $urandom_range(0, 7) != 0);
        end
        if ($urandom_range(0, 9) == 0) begin
          send_rule(IDX_W'(0), $urandom, $urandom, 1'b0);
        end
        nf = $urandom_range(2, 5);
        for (int f = 0; f < nf; f++) begin
          kind = $urandom_range(0, 9);
          if (kind == 0) begin
            len = $urandom_range(1, 33);
          end else if ($urandom_range(0, 7) == 0) begin
            len = $urandom_range(64, 100);
          end else begin
            len = $urandom_range(34, 63);
          end
          if (kind == 1) begin
            etype = 16'($urandom_range(0, 16'hFFFF));
          end else if (kind == 2) begin
            etype = TYPE_IPV4 ^ (16'h1 << $urandom_range(0, 15));
          end else begin
            etype = TYPE_IPV4;
          end
          if ($urandom_range(0, 1) == 1) begin
            j   = $urandom_range(0, 7);
            src = (blk_addr[j] & blk_mask[j]) | ($urandom & ~blk_mask[j]);
          end else begin
            src = $urandom;
          end
          send_frame(len, etype, src, kind == 3);
        end
      end
      if (phase_no == 0 || $urandom_range(0, 4) == 0) begin
        drain_verdicts();
      end
      phase_no++;
    end

    // Wait out the pipeline, then report
    drain_verdicts();
    repeat (RULE_DEPTH + 8) @(negedge clk);
    if (errors == 0) begin
      $display("ipv4_source_range_filter verification clean");
    end else begin
      $display("ipv4_source_range_filter verification failed");
    end
    $finish;
  end

endmodule
